// File: hw/rtl/lcg_pkg.sv
package lcg_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAG_WIDTH    = SAMPLE_WIDTH - 1;
    localparam int PHASE_WIDTH  = 32;
    localparam int STEP_WIDTH   = 48;
    localparam int CFG_WIDTH    = 32;
    localparam int GAIN_WIDTH   = 16;

    localparam logic [MAG_WIDTH-1:0] FULL_SCALE = {MAG_WIDTH{1'b1}};
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_DISARM = 2'd2;

    localparam logic [1:0] CFG_START_STEP = 2'd0;
    localparam logic [1:0] CFG_STEP_INC   = 2'd1;
    localparam logic [1:0] CFG_GAIN       = 2'd2;
    localparam logic [1:0] CFG_DURATION   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] sample_num;
    } cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        logic                           sweep_running;
    } res_t;

    typedef struct packed {
        logic                 neg;
        logic [MAG_WIDTH-1:0] mag;
    } sine_t;

endpackage

// File: hw/rtl/lcg_sine_rom.sv
module lcg_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic [lcg_pkg::PHASE_WIDTH-1:0] phase,
    output lcg_pkg::sine_t                  sine
);

    localparam int IdxW  = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int KW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int ProdW = lcg_pkg::PHASE_WIDTH + IdxW;

    function automatic logic [lcg_pkg::MAG_WIDTH-1:0] quarter_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (lcg_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        sum  = $signed(x);
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = (64'(sum) * 64'(lcg_pkg::FULL_SCALE) + 64'd536870912) >> 30;
        if (v > 64'(lcg_pkg::FULL_SCALE))
        begin
            v = 64'(lcg_pkg::FULL_SCALE);
        end
        return v[lcg_pkg::MAG_WIDTH-1:0];
    endfunction

    logic [lcg_pkg::MAG_WIDTH-1:0] rom [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_rom
        assign rom[g] = quarter_entry(g);
    end

    logic [ProdW-1:0] prod;
    logic [IdxW-1:0]  idx;
    logic [IdxW-1:0]  k;
    logic [1:0]       quad;
    logic [KW-1:0]    addr;
    lcg_pkg::sine_t   sine_reg;

    always_comb
    begin
        prod = {{IdxW{1'b0}}, phase} * ProdW'(4 * SINE_TABLE_DEPTH);
        idx  = prod[ProdW-1:lcg_pkg::PHASE_WIDTH];
        if (idx >= IdxW'(3 * SINE_TABLE_DEPTH))
        begin
            quad = 2'd3;
            k    = idx - IdxW'(3 * SINE_TABLE_DEPTH);
        end
        else if (idx >= IdxW'(2 * SINE_TABLE_DEPTH))
        begin
            quad = 2'd2;
            k    = idx - IdxW'(2 * SINE_TABLE_DEPTH);
        end
        else if (idx >= IdxW'(SINE_TABLE_DEPTH))
        begin
            quad = 2'd1;
            k    = idx - IdxW'(SINE_TABLE_DEPTH);
        end
        else
        begin
            quad = 2'd0;
            k    = idx;
        end
        addr = quad[0] ? (KW'(SINE_TABLE_DEPTH) - KW'(k)) : KW'(k);
    end

    always_ff @(posedge clk)
    begin
        sine_reg.mag <= rom[addr];
        sine_reg.neg <= quad[1];
    end

    assign sine = sine_reg;

endmodule

// File: hw/rtl/linear_chirp_generator.sv
// a command transfer is held in the input register, and its result in the result register
// one command per cycle while res_stall is low; phase and step recurrences are one add each
// the sine for the next phase is read from the quarter-wave rom in the same cycle as the update
// reset clears the sweep state, the configuration registers and both handshake stages
// the sine rom output register is not reset and is reloaded on every clock
module linear_chirp_generator #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  lcg_pkg::cmd_t                 cmd,
    output logic                          res_valid,
    input  logic                          res_stall,
    output lcg_pkg::res_t                 res,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [lcg_pkg::CFG_WIDTH-1:0] cfg_data
);

    localparam int SW = lcg_pkg::SAMPLE_WIDTH;
    localparam int MW = lcg_pkg::MAG_WIDTH;

    // configuration
    logic [31:0]                      start_step_reg;
    logic [31:0]                      step_inc_reg;
    logic [lcg_pkg::GAIN_WIDTH-1:0]   gain_reg;
    logic [31:0]                      duration_reg;

    // sweep state
    logic [lcg_pkg::PHASE_WIDTH-1:0]  phase_acc_reg, phase_acc_next;
    logic [lcg_pkg::STEP_WIDTH-1:0]   current_step_reg, current_step_next;
    logic [31:0]                      start_index_reg, start_index_next;
    logic                             index_latched_reg, index_latched_next;
    logic                             armed_reg, armed_next;
    logic                             running_reg, running_next;

    // handshake stages
    logic                             cmd_valid_reg;
    lcg_pkg::cmd_t                    cmd_reg;
    logic                             res_valid_reg;
    lcg_pkg::res_t                    res_reg;
    lcg_pkg::res_t                    res_next;

    lcg_pkg::sine_t                   sine;
    logic                             process;
    logic [31:0]                      start_eff;
    logic [31:0]                      elapsed;
    logic                             done;
    logic [31:0]                      product;
    logic [31:0]                      rounded;
    logic [16:0]                      scaled;
    logic [MW-1:0]                    mag_sat;
    logic [SW-1:0]                    mag_ext;
    logic [SW-1:0]                    value;

    lcg_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk  (clk),
        .phase(phase_acc_next),
        .sine (sine)
    );

    assign process   = cmd_valid_reg & (~res_valid_reg | ~res_stall);
    assign cmd_stall = cmd_valid_reg & res_valid_reg & res_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // sample scaling
    always_comb
    begin
        product = 32'(gain_reg) * 32'(sine.mag);
        rounded = product + 32'd16384;
        scaled  = rounded[31:15];
        mag_sat = (scaled > 17'(lcg_pkg::FULL_SCALE)) ? lcg_pkg::FULL_SCALE : scaled[MW-1:0];
        mag_ext = SW'(mag_sat);
        value   = sine.neg ? (~mag_ext + SW'(1)) : mag_ext;
    end

    always_comb
    begin
        start_eff = index_latched_reg ? start_index_reg : cmd_reg.sample_num;
        elapsed   = cmd_reg.sample_num - start_eff;
        done      = elapsed >= duration_reg;
    end

    always_comb
    begin
        phase_acc_next         = phase_acc_reg;
        current_step_next      = current_step_reg;
        start_index_next       = start_index_reg;
        index_latched_next     = index_latched_reg;
        armed_next             = armed_reg;
        running_next           = running_reg;
        res_next.sample_value  = '0;
        res_next.sweep_running = 1'b0;
        if (process)
        begin
            case (cmd_reg.op)
                lcg_pkg::OP_ARM:
                begin
                    current_step_next      = {start_step_reg, 16'h0000};
                    phase_acc_next         = '0;
                    start_index_next       = '0;
                    index_latched_next     = 1'b0;
                    armed_next             = 1'b1;
                    running_next           = 1'b1;
                    res_next.sweep_running = 1'b1;
                end
                lcg_pkg::OP_DISARM:
                begin
                    current_step_next  = '0;
                    phase_acc_next     = '0;
                    start_index_next   = '0;
                    index_latched_next = 1'b0;
                    armed_next         = 1'b0;
                    running_next       = 1'b0;
                end
                lcg_pkg::OP_SAMPLE:
                begin
                    if (armed_reg && running_reg)
                    begin
                        if (!index_latched_reg)
                        begin
                            start_index_next   = cmd_reg.sample_num;
                            index_latched_next = 1'b1;
                        end
                        if (done)
                        begin
                            running_next = 1'b0;
                        end
                        else
                        begin
                            res_next.sample_value  = value;
                            res_next.sweep_running = 1'b1;
                            phase_acc_next    = phase_acc_reg + current_step_reg[47:16];
                            current_step_next = current_step_reg
                                                + {{16{step_inc_reg[31]}}, step_inc_reg};
                        end
                    end
                end
                default:
                begin
                    res_next.sweep_running = armed_reg & running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_step_reg    <= '0;
            step_inc_reg      <= '0;
            gain_reg          <= '0;
            duration_reg      <= '0;
            phase_acc_reg     <= '0;
            current_step_reg  <= '0;
            start_index_reg   <= '0;
            index_latched_reg <= 1'b0;
            armed_reg         <= 1'b0;
            running_reg       <= 1'b0;
            cmd_valid_reg     <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lcg_pkg::CFG_START_STEP: start_step_reg <= cfg_data;
                    lcg_pkg::CFG_STEP_INC:   step_inc_reg   <= cfg_data;
                    lcg_pkg::CFG_GAIN:       gain_reg       <= cfg_data[lcg_pkg::GAIN_WIDTH-1:0];
                    lcg_pkg::CFG_DURATION:   duration_reg   <= cfg_data;
                    default:                 duration_reg   <= duration_reg;
                endcase
            end
            phase_acc_reg     <= phase_acc_next;
            current_step_reg  <= current_step_next;
            start_index_reg   <= start_index_next;
            index_latched_reg <= index_latched_next;
            armed_reg         <= armed_next;
            running_reg       <= running_next;
            if (cmd_valid && !cmd_stall)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                cmd_valid_reg <= 1'b0;
            end
            if (process)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
        if (process)
        begin
            res_reg <= res_next;
        end
    end

    a_running_armed: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> armed_reg)
        else $error("sweep running while not armed");

    a_latch_armed: assert property (@(posedge clk) disable iff (!rst_n)
        index_latched_reg |-> armed_reg)
        else $error("start index latched while not armed");

    a_value_running: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.sample_value != '0) |-> res.sweep_running)
        else $error("nonzero sample without running flag");

    a_arm_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (process && cmd_reg.op == lcg_pkg::OP_ARM)
            |=> (phase_acc_reg == '0 && current_step_reg[15:0] == 16'h0000 && running_reg))
        else $error("arm did not restart the sweep");

    a_disarm_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (process && cmd_reg.op == lcg_pkg::OP_DISARM)
            |=> (!armed_reg && !index_latched_reg && current_step_reg == '0))
        else $error("disarm did not clear the sweep");

endmodule

// File: tb/lcg_checker.sv
module lcg_checker #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_stall,
    input  lcg_pkg::cmd_t                 cmd,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  lcg_pkg::res_t                 res,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [lcg_pkg::CFG_WIDTH-1:0] cfg_data,
    output int                            fail_count,
    output int                            samples_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = lcg_pkg::SAMPLE_WIDTH;

    int sine_rom [0:SINE_TABLE_DEPTH];

    logic [31:0]                    start_step_reg;
    logic [31:0]                    step_inc_reg;
    logic [lcg_pkg::GAIN_WIDTH-1:0] gain_reg;
    logic [31:0]                    duration_reg;

    logic [lcg_pkg::PHASE_WIDTH-1:0] phase_acc;
    logic [lcg_pkg::STEP_WIDTH-1:0]  step_acc;
    logic [31:0]                     first_index;
    bit                              index_held;
    bit                              armed;
    bit                              sweeping;

    lcg_pkg::res_t owed_samples [$];

    function automatic int quarter_sine(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned scaled;
        longint          sum;
        x = (64'(lcg_pkg::HALF_PI_Q30) * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        scaled = (64'(sum) * 64'(lcg_pkg::FULL_SCALE) + 64'd536870912) >> 30;
        if (scaled > 64'(lcg_pkg::FULL_SCALE))
            scaled = 64'(lcg_pkg::FULL_SCALE);
        return int'(scaled);
    endfunction

    function automatic int sine_at(logic [lcg_pkg::PHASE_WIDTH-1:0] ph);
        longint unsigned slot;
        int              quad;
        int              k;
        int              v;
        slot = (64'(ph) * 64'(4 * SINE_TABLE_DEPTH)) >> 32;
        quad = int'((slot / SINE_TABLE_DEPTH) % 4);
        k = int'(slot % SINE_TABLE_DEPTH);
        v = (quad % 2 == 1) ? sine_rom[SINE_TABLE_DEPTH - k] : sine_rom[k];
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic void clear_sweep();
        phase_acc = '0;
        step_acc = '0;
        first_index = '0;
        index_held = 0;
        armed = 0;
        sweeping = 0;
    endfunction

    function automatic lcg_pkg::res_t chirp_next(lcg_pkg::cmd_t c);
        lcg_pkg::res_t   r;
        logic [31:0]     elapsed;
        int              s;
        longint unsigned mag;
        r = '0;
        case (c.op)
            lcg_pkg::OP_ARM:
            begin
                step_acc = {start_step_reg, 16'h0000};
                phase_acc = '0;
                first_index = '0;
                index_held = 0;
                armed = 1;
                sweeping = 1;
                r.sweep_running = 1'b1;
            end
            lcg_pkg::OP_DISARM:
                clear_sweep();
            lcg_pkg::OP_SAMPLE:
            begin
                if (armed && sweeping)
                begin
                    if (!index_held)
                    begin
                        first_index = c.sample_num;
                        index_held = 1;
                    end
                    elapsed = c.sample_num - first_index;
                    if (elapsed >= duration_reg)
                        sweeping = 0;
                    else
                    begin
                        s = sine_at(phase_acc);
                        mag = (64'(gain_reg) * 64'((s < 0) ? -s : s) + 64'd16384) >> 15;
                        if (mag > 64'(lcg_pkg::FULL_SCALE))
                            mag = 64'(lcg_pkg::FULL_SCALE);
                        r.sample_value = (s < 0) ? SW'(-mag) : SW'(mag);
                        r.sweep_running = 1'b1;
                        phase_acc = phase_acc + step_acc[lcg_pkg::STEP_WIDTH-1:16];
                        step_acc = step_acc + {{16{step_inc_reg[31]}}, step_inc_reg};
                    end
                end
            end
            default:
                r.sweep_running = armed && sweeping;
        endcase
        return r;
    endfunction

    initial
    begin
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
            sine_rom[k] = quarter_sine(k);
    end

    always @(posedge clk or negedge rst_n)
    begin
        lcg_pkg::res_t want;
        if (!rst_n)
        begin
            start_step_reg = '0;
            step_inc_reg = '0;
            gain_reg = '0;
            duration_reg = '0;
            clear_sweep();
            owed_samples.delete();
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (owed_samples.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: sample_value %0d sweep_running %0b",
                                 res.sample_value, res.sweep_running);
                end
                else
                begin
                    want = owed_samples.pop_front();
                    if (res.sample_value !== want.sample_value ||
                        res.sweep_running !== want.sweep_running)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: sample_value exp %0d got %0d, %s%0b got %0b",
                                     want.sample_value, res.sample_value, "sweep_running exp ",
                                     want.sweep_running, res.sweep_running);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lcg_pkg::CFG_START_STEP: start_step_reg = cfg_data;
                    lcg_pkg::CFG_STEP_INC:   step_inc_reg = cfg_data;
                    lcg_pkg::CFG_GAIN:       gain_reg = cfg_data[lcg_pkg::GAIN_WIDTH-1:0];
                    lcg_pkg::CFG_DURATION:   duration_reg = cfg_data;
                    default:                 ;
                endcase
            end
            if (cmd_valid && !cmd_stall)
                owed_samples.push_back(chirp_next(cmd));
        end
        samples_owed = owed_samples.size();
    end

endmodule

// File: tb/tb_linear_chirp_generator.sv
module tb_linear_chirp_generator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         TABLE_DEPTH = 1024;
    localparam logic [1:0] OP_IGNORED  = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          cmd_valid;
    logic                          cmd_stall;
    lcg_pkg::cmd_t                 cmd;
    logic                          res_valid;
    logic                          res_stall;
    lcg_pkg::res_t                 res;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index;
    logic [lcg_pkg::CFG_WIDTH-1:0] cfg_data;

    int fail_count;
    int samples_owed;
    bit drain_hold;
    bit quiet;

    linear_chirp_generator #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    lcg_checker #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .samples_owed(samples_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            res_stall = drain_hold || (!quiet && $urandom_range(99) < 12);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_sweep(input logic [31:0] start_step, input logic [31:0] step_inc,
                              input logic [15:0] gain, input logic [31:0] duration);
        write_reg(lcg_pkg::CFG_START_STEP, start_step);
        write_reg(lcg_pkg::CFG_STEP_INC, step_inc);
        write_reg(lcg_pkg::CFG_GAIN, {16'h0000, gain});
        write_reg(lcg_pkg::CFG_DURATION, duration);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send(input logic [1:0] op, input logic [31:0] idx);
        if (!quiet)
        begin
            while ($urandom_range(99) < 12)
            begin
                @(negedge clk);
                cmd_valid = 1'b0;
            end
        end
        @(negedge clk);
        cmd_valid = 1'b1;
        cmd.op = op;
        cmd.sample_num = idx;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        cmd_valid = 1'b0;
        wait (samples_owed == 0);
        repeat (4) @(posedge clk);
    endtask

    // well-formed sweeps with random content, plus stray commands
    task automatic run_sweeps(input int target, input logic [31:0] duration);
        int          sent;
        int          len;
        logic [31:0] base;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(99) < 12)
            begin
                send(2'($urandom_range(3)), $urandom);
                sent++;
            end
            else
            begin
                send(lcg_pkg::OP_ARM, $urandom);
                sent++;
                base = $urandom;
                len = $urandom_range(((duration > 40) ? 40 : duration) + 4);
                for (int i = 0; i < len; i++)
                begin
                    send(lcg_pkg::OP_SAMPLE, ($urandom_range(99) < 5) ? $urandom : base + i);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [31:0] start_v;
        logic [31:0] inc_v;
        logic [15:0] gain_v;
        logic [31:0] dur_v;

        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = lcg_pkg::CFG_START_STEP;
        cfg_data = '0;
        drain_hold = 0;
        quiet = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // saturating gain, short sweep across the index wrap
        load_sweep(32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF, 32'd5);
        send(lcg_pkg::OP_SAMPLE, 32'd0);
        send(OP_IGNORED, 32'd0);
        send(lcg_pkg::OP_DISARM, 32'hFFFF_FFFF);
        send(lcg_pkg::OP_ARM, 32'd0);
        send(OP_IGNORED, 32'd7);
        send(lcg_pkg::OP_SAMPLE, 32'hFFFF_FFFE);
        send(lcg_pkg::OP_SAMPLE, 32'hFFFF_FFFF);
        send(lcg_pkg::OP_SAMPLE, 32'd0);
        send(lcg_pkg::OP_SAMPLE, 32'd1);
        send(lcg_pkg::OP_SAMPLE, 32'd2);
        send(lcg_pkg::OP_SAMPLE, 32'd3);
        send(lcg_pkg::OP_SAMPLE, 32'd0);
        send(OP_IGNORED, 32'd0);
        send(lcg_pkg::OP_ARM, 32'd0);
        send(lcg_pkg::OP_SAMPLE, 32'd100);
        send(lcg_pkg::OP_DISARM, 32'd0);
        send(lcg_pkg::OP_SAMPLE, 32'd101);
        settle();

        // zero duration ends on the first sample
        load_sweep(32'd0, 32'h7FFF_FFFF, 16'd0, 32'd0);
        send(lcg_pkg::OP_ARM, 32'd0);
        send(lcg_pkg::OP_SAMPLE, 32'h5555_AAAA);
        settle();

        // quarter-turn steps visit every quadrant at unity gain
        load_sweep(32'h4000_0000, 32'hFFFF_FFFF, 16'd32768, 32'hFFFF_FFFF);
        send(lcg_pkg::OP_ARM, 32'd0);
        repeat (5) send(lcg_pkg::OP_SAMPLE, 32'hAAAA_5555);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(3))
                0:       start_v = 32'd0;
                1:       start_v = 32'hFFFF_FFFF;
                2:       start_v = $urandom_range(32'h00FF_FFFF);
                default: start_v = $urandom;
            endcase
            case ($urandom_range(3))
                0:       inc_v = 32'h8000_0000;
                1:       inc_v = 32'h7FFF_FFFF;
                2:       inc_v = $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
                default: inc_v = $urandom;
            endcase
            case ($urandom_range(7))
                0:       gain_v = 16'd0;
                1:       gain_v = 16'd32768;
                2:       gain_v = 16'hFFFF;
                default: gain_v = 16'($urandom_range(32768));
            endcase
            case ($urandom_range(7))
                0:       dur_v = 32'd0;
                1:       dur_v = 32'hFFFF_FFFF;
                2:       dur_v = 32'd1;
                default: dur_v = $urandom_range(48, 2);
            endcase
            quiet = (p == 3);
            load_sweep(start_v, inc_v, gain_v, dur_v);
            if (p == 5)
            begin
                fork
                    run_sweeps(145, dur_v);
                    begin
                        repeat (40) @(posedge clk);
                        drain_hold = 1;
                        repeat (120) @(posedge clk);
                        drain_hold = 0;
                    end
                join
            end
            else
                run_sweeps(145, dur_v);
            settle();
            quiet = 0;
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && samples_owed == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
